// ===== sv/tewd_pkg.sv =====
// Package for the timing event word decoder: event codes, report kinds,
// the stored time byte set and the result record shared by all modules.
// No dependencies.
`default_nettype none

package tewd_pkg;

  localparam int unsigned CODE_W   = 8;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned WORD_W   = CODE_W + DATA_W;
  localparam int unsigned NIBBLE_W = 4;
  localparam int unsigned DAY_W    = 24;
  localparam int unsigned SEC_W    = 30;
  localparam int unsigned MS_W     = 10;

  // Event codes with a meaning of their own.
  localparam logic [CODE_W-1:0] CODE_TIMING_MAX = 8'd199;
  localparam logic [CODE_W-1:0] CODE_DAY_HIGH   = 8'd209;
  localparam logic [CODE_W-1:0] CODE_DAY_MID    = 8'd210;
  localparam logic [CODE_W-1:0] CODE_DAY_DONE   = 8'd211;
  localparam logic [CODE_W-1:0] CODE_UTC_ONE    = 8'd224;
  localparam logic [CODE_W-1:0] CODE_UTC_TWO    = 8'd225;
  localparam logic [CODE_W-1:0] CODE_UTC_THREE  = 8'd226;
  localparam logic [CODE_W-1:0] CODE_UTC_FOUR   = 8'd227;
  localparam logic [CODE_W-1:0] CODE_UTC_DONE   = 8'd228;

  typedef enum logic [1:0] {
    KIND_TIMING = 2'd0,
    KIND_DAY    = 2'd1,
    KIND_UTC    = 2'd2,
    KIND_OTHER  = 2'd3
  } kind_t;

  // Time bytes collected from the storing codes.
  typedef struct packed {
    logic [DATA_W-1:0] day_byte_high;
    logic [DATA_W-1:0] day_byte_mid;
    logic [DATA_W-1:0] utc_byte_one;
    logic [DATA_W-1:0] utc_byte_two;
    logic [DATA_W-1:0] utc_byte_three;
    logic [DATA_W-1:0] utc_byte_four;
  } time_bytes_t;

  typedef struct packed {
    kind_t               kind;
    logic [CODE_W-1:0]   code;
    logic [NIBBLE_W-1:0] virtual_accel;
    logic [NIBBLE_W-1:0] beam_status;
    logic [DAY_W-1:0]    day_ticks;
    logic [SEC_W-1:0]    utc_seconds;
    logic [MS_W-1:0]     utc_millis;
    logic [DATA_W-1:0]   raw_data;
  } report_t;

endpackage

`default_nettype wire

// ===== sv/tewd_decode.sv =====
// Combinational decode of one timing event word against the stored time bytes.
// Depends on tewd_pkg.
`default_nettype none

module tewd_decode (
  input  wire logic [tewd_pkg::WORD_W-1:0] word,
  input  wire tewd_pkg::time_bytes_t       bytes_now,
  output tewd_pkg::time_bytes_t            bytes_next,
  output logic                             has_report,
  output tewd_pkg::report_t                report
);

  logic [tewd_pkg::CODE_W-1:0] code;
  logic [tewd_pkg::DATA_W-1:0] data;

  assign code = word[tewd_pkg::CODE_W-1:0];
  assign data = word[tewd_pkg::WORD_W-1:tewd_pkg::CODE_W];

  always_comb begin
    bytes_next  = bytes_now;
    has_report  = 1'b0;
    report      = '0;
    report.code = code;
    report.kind = tewd_pkg::KIND_OTHER;
    case (code)
      tewd_pkg::CODE_DAY_HIGH:  bytes_next.day_byte_high  = data;
      tewd_pkg::CODE_DAY_MID:   bytes_next.day_byte_mid   = data;
      tewd_pkg::CODE_UTC_ONE:   bytes_next.utc_byte_one   = data;
      tewd_pkg::CODE_UTC_TWO:   bytes_next.utc_byte_two   = data;
      tewd_pkg::CODE_UTC_THREE: bytes_next.utc_byte_three = data;
      tewd_pkg::CODE_UTC_FOUR:  bytes_next.utc_byte_four  = data;
      tewd_pkg::CODE_DAY_DONE: begin
        has_report       = 1'b1;
        report.kind      = tewd_pkg::KIND_DAY;
        report.day_ticks = {bytes_now.day_byte_high, bytes_now.day_byte_mid, data};
      end
      tewd_pkg::CODE_UTC_DONE: begin
        has_report         = 1'b1;
        report.kind        = tewd_pkg::KIND_UTC;
        report.utc_seconds = {bytes_now.utc_byte_two[5:0], bytes_now.utc_byte_three,
                              bytes_now.utc_byte_four, data};
        // Milliseconds take the first byte and the top two bits of the second.
        report.utc_millis  = {bytes_now.utc_byte_one, bytes_now.utc_byte_two[7:6]};
      end
      default: begin
        has_report = 1'b1;
        if (code <= tewd_pkg::CODE_TIMING_MAX) begin
          report.kind          = tewd_pkg::KIND_TIMING;
          report.virtual_accel = data[tewd_pkg::NIBBLE_W-1:0];
          report.beam_status   = data[tewd_pkg::DATA_W-1:tewd_pkg::NIBBLE_W];
        end else begin
          report.raw_data = data;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/timing_event_word_decoder.sv =====
// Top level of the timing event word decoder.
// Depends on tewd_pkg and tewd_decode.
`default_nettype none

// The decoder takes one 16-bit timing event word per transfer (code in the
// low byte, data in the high byte) and gives at most one report per word.
// Codes 0 to 199 report a timing event with accelerator number and beam
// status; codes 209, 210 and 224 to 227 only store time bytes and give no
// report; code 211 reports the day time in 10 ms ticks and code 228 reports
// UTC seconds and milliseconds from the stored bytes; every other code is
// reported raw. A word is taken into an input register, decoded by a short
// case on its code, and the report lands in an output register, so a word
// can be accepted in every cycle: throughput is one word per cycle while no
// report waits on a stalled output, and the report of a word passes the
// input register and then the output register before it can be taken. A stalled
// output holds back only words that give a report; storing words still
// pass. The stored bytes are cleared by reset.
module timing_event_word_decoder (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [tewd_pkg::WORD_W-1:0]          event_word,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [1:0]                                report_kind,
  output logic [tewd_pkg::CODE_W-1:0]               event_code,
  output logic [tewd_pkg::NIBBLE_W-1:0]             virtual_accel,
  output logic [tewd_pkg::NIBBLE_W-1:0]             beam_status,
  output logic [tewd_pkg::DAY_W-1:0]                day_ticks,
  output logic [tewd_pkg::SEC_W-1:0]                utc_seconds,
  output logic [tewd_pkg::MS_W-1:0]                 utc_millis,
  output logic [tewd_pkg::DATA_W-1:0]               raw_data
);

  // Input register stage.
  logic                          word_valid;
  logic [tewd_pkg::WORD_W-1:0]   word;

  // Stored time bytes and their value after the word in the input register.
  tewd_pkg::time_bytes_t         time_bytes;
  tewd_pkg::time_bytes_t         time_bytes_next;

  logic                          has_report;
  tewd_pkg::report_t             report_next;
  tewd_pkg::report_t             report;

  logic                          out_free;
  logic                          word_done;

  tewd_decode u_decode (
    .word       (word),
    .bytes_now  (time_bytes),
    .bytes_next (time_bytes_next),
    .has_report (has_report),
    .report     (report_next)
  );

  // The output register is free when empty or when its report is being
  // taken this cycle. A word without a report never waits for it.
  assign out_free  = !out_valid || out_ready;
  assign word_done = word_valid && (!has_report || out_free);
  assign in_ready  = !word_valid || word_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
      out_valid  <= 1'b0;
      time_bytes <= '0;
    end else begin
      if (in_ready) begin
        word_valid <= in_valid;
      end
      if (word_done) begin
        time_bytes <= time_bytes_next;
      end
      if (word_done && has_report) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= event_word;
    end
    if (word_done && has_report) begin
      report <= report_next;
    end
  end

  assign report_kind   = report.kind;
  assign event_code    = report.code;
  assign virtual_accel = report.virtual_accel;
  assign beam_status   = report.beam_status;
  assign day_ticks     = report.day_ticks;
  assign utc_seconds   = report.utc_seconds;
  assign utc_millis    = report.utc_millis;
  assign raw_data      = report.raw_data;

`ifndef SYNTHESIS
  // Reset leaves both stages empty.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!word_valid && !out_valid))
    else $error("stages not empty after reset");

  // The input side only stalls behind a word that waits for the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (word_valid && has_report && out_valid && !out_ready))
    else $error("input stalled without a waiting report");

  // A timing event report carries none of the time or raw fields.
  a_timing_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && report_kind == tewd_pkg::KIND_TIMING) |->
      (day_ticks == '0 && utc_seconds == '0 && utc_millis == '0 && raw_data == '0))
    else $error("timing report with stray fields");

  // Stored bytes change only when a word leaves the input register.
  a_bytes_hold: assert property (@(posedge clk) disable iff (rst)
    !word_done |=> $stable(time_bytes))
    else $error("time bytes changed without a word");
`endif

endmodule

`default_nettype wire

// ===== sim/timing_event_word_decoder_tb.sv =====
// Self-checking testbench for timing_event_word_decoder: directed and random
// event words with random stalls on both channels, checked by a scoreboard.
// Depends on tewd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module timing_event_word_decoder_tb;

  localparam int unsigned WORD_W   = tewd_pkg::WORD_W;
  localparam int unsigned CODE_W   = tewd_pkg::CODE_W;
  localparam int unsigned DATA_W   = tewd_pkg::DATA_W;
  localparam int unsigned NIBBLE_W = tewd_pkg::NIBBLE_W;
  localparam int unsigned DAY_W    = tewd_pkg::DAY_W;
  localparam int unsigned SEC_W    = tewd_pkg::SEC_W;
  localparam int unsigned MS_W     = tewd_pkg::MS_W;

  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned HOLD_WORDS   = 40;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // Scoreboard: it keeps its own copy of the stored time bytes, predicts the
  // report that each accepted word causes and checks reports in order.
  class event_scoreboard;
    tewd_pkg::time_bytes_t bytes;
    tewd_pkg::report_t     pending[$];
    int unsigned           fails;

    function new();
      bytes = '0;
      fails = 0;
    endfunction

    function void note_word(logic [WORD_W-1:0] word);
      logic [CODE_W-1:0] code;
      logic [DATA_W-1:0] data;
      tewd_pkg::report_t rep;
      code = word[CODE_W-1:0];
      data = word[WORD_W-1:CODE_W];
      rep  = '0;
      case (code)
        tewd_pkg::CODE_DAY_HIGH:  bytes.day_byte_high  = data;
        tewd_pkg::CODE_DAY_MID:   bytes.day_byte_mid   = data;
        tewd_pkg::CODE_UTC_ONE:   bytes.utc_byte_one   = data;
        tewd_pkg::CODE_UTC_TWO:   bytes.utc_byte_two   = data;
        tewd_pkg::CODE_UTC_THREE: bytes.utc_byte_three = data;
        tewd_pkg::CODE_UTC_FOUR:  bytes.utc_byte_four  = data;
        default: begin
          rep.code = code;
          if (code <= tewd_pkg::CODE_TIMING_MAX) begin
            rep.kind          = tewd_pkg::KIND_TIMING;
            rep.virtual_accel = data[3:0];
            rep.beam_status   = data[7:4];
          end else if (code == tewd_pkg::CODE_DAY_DONE) begin
            rep.kind      = tewd_pkg::KIND_DAY;
            rep.day_ticks = {bytes.day_byte_high, bytes.day_byte_mid, data};
          end else if (code == tewd_pkg::CODE_UTC_DONE) begin
            rep.kind        = tewd_pkg::KIND_UTC;
            rep.utc_seconds = {bytes.utc_byte_two[5:0], bytes.utc_byte_three,
                               bytes.utc_byte_four, data};
            rep.utc_millis  = {bytes.utc_byte_one, bytes.utc_byte_two[7:6]};
          end else begin
            rep.kind     = tewd_pkg::KIND_OTHER;
            rep.raw_data = data;
          end
          pending.push_back(rep);
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, seen);
        fails++;
      end
    endfunction

    function void check_report(tewd_pkg::report_t seen);
      tewd_pkg::report_t want;
      if (pending.size() == 0) begin
        $error("report of kind %0d, code %0d arrived with none expected",
               seen.kind, seen.code);
        fails++;
      end else begin
        want = pending.pop_front();
        compare_field("report_kind",   want.kind,          seen.kind);
        compare_field("event_code",    want.code,          seen.code);
        compare_field("virtual_accel", want.virtual_accel, seen.virtual_accel);
        compare_field("beam_status",   want.beam_status,   seen.beam_status);
        compare_field("day_ticks",     want.day_ticks,     seen.day_ticks);
        compare_field("utc_seconds",   want.utc_seconds,   seen.utc_seconds);
        compare_field("utc_millis",    want.utc_millis,    seen.utc_millis);
        compare_field("raw_data",      want.raw_data,      seen.raw_data);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [WORD_W-1:0]   event_word;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          report_kind;
  logic [CODE_W-1:0]   event_code;
  logic [NIBBLE_W-1:0] virtual_accel;
  logic [NIBBLE_W-1:0] beam_status;
  logic [DAY_W-1:0]    day_ticks;
  logic [SEC_W-1:0]    utc_seconds;
  logic [MS_W-1:0]     utc_millis;
  logic [DATA_W-1:0]   raw_data;

  event_scoreboard     sb = new();
  int unsigned         words_sent = 0;
  int unsigned         cycles = 0;

  // Traffic shaping shared by the sender and the receiver. With idle_on
  // cleared neither side idles; hold_req asks the receiver for one long
  // hold-off while the sender keeps offering words.
  bit                  idle_on = 1'b1;
  bit                  hold_req = 1'b0;

  timing_event_word_decoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .event_word    (event_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .report_kind   (report_kind),
    .event_code    (event_code),
    .virtual_accel (virtual_accel),
    .beam_status   (beam_status),
    .day_ticks     (day_ticks),
    .utc_seconds   (utc_seconds),
    .utc_millis    (utc_millis),
    .raw_data      (raw_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a stuck handshake or a lost report ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Monitor: both channels are sampled at the rising edge, before the block
  // updates its registers. The report transfer is checked before the word
  // transfer of the same edge is noted; a report passes the input and output
  // registers before it is taken, so it never belongs to a word accepted at
  // that same edge.
  always @(posedge clk) begin : monitor
    tewd_pkg::report_t seen;
    if (!rst) begin
      if (out_valid && out_ready) begin
        seen.kind          = tewd_pkg::kind_t'(report_kind);
        seen.code          = event_code;
        seen.virtual_accel = virtual_accel;
        seen.beam_status   = beam_status;
        seen.day_ticks     = day_ticks;
        seen.utc_seconds   = utc_seconds;
        seen.utc_millis    = utc_millis;
        seen.raw_data      = raw_data;
        sb.check_report(seen);
      end
      if (in_valid && in_ready) begin
        sb.note_word(event_word);
      end
    end
  end

  // Receiver: every turn sets out_ready once at a falling edge and keeps it
  // for a random span. With idling on it alternates ready stretches and
  // stall bursts; a hold request gives one long stall.
  initial begin : receiver
    int unsigned span;
    logic        level;
    bit          stall_turn;
    stall_turn = 1'b0;
    out_ready  = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        level    = 1'b0;
        span     = LONG_HOLD;
      end else if (!idle_on) begin
        level = 1'b1;
        span  = 1;
      end else begin
        stall_turn = !stall_turn;
        level      = !stall_turn;
        span       = stall_turn ? $urandom_range(1, 6) : $urandom_range(1, 16);
      end
      out_ready <= level;
      repeat (span) @(negedge clk);
    end
  end

  function automatic logic [DATA_W-1:0] rand_byte();
    return DATA_W'($urandom_range(0, 255));
  endfunction

  // Offers one word and returns at the falling edge after its transfer.
  // Called at a falling edge; a random gap may come first.
  task automatic send_word(input logic [DATA_W-1:0] data, input logic [CODE_W-1:0] code);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    event_word <= {data, code};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // Stops offering words and holds the sender until every predicted report
  // has been taken. Called at a falling edge.
  task automatic wait_reports_done();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    // Completions straight after reset use the cleared byte registers.
    send_word(8'hff, tewd_pkg::CODE_DAY_DONE);
    send_word(8'ha5, tewd_pkg::CODE_UTC_DONE);
    // Edges of the timing range and of the raw code ranges.
    send_word(8'h00, 8'd0);
    send_word(8'hff, tewd_pkg::CODE_TIMING_MAX);
    send_word(8'h5a, tewd_pkg::CODE_TIMING_MAX + 8'd1);
    send_word(8'hff, tewd_pkg::CODE_DAY_HIGH - 8'd1);
    send_word(8'h00, tewd_pkg::CODE_DAY_DONE + 8'd1);
    send_word(8'hff, tewd_pkg::CODE_UTC_ONE - 8'd1);
    send_word(8'h3c, tewd_pkg::CODE_UTC_DONE + 8'd1);
    send_word(8'hff, 8'd255);
    // A full day time, then a second completion that reuses the bytes.
    send_word(8'hff, tewd_pkg::CODE_DAY_HIGH);
    send_word(8'h00, tewd_pkg::CODE_DAY_MID);
    send_word(8'h81, tewd_pkg::CODE_DAY_DONE);
    send_word(8'h7e, tewd_pkg::CODE_DAY_DONE);
    // A full UTC time with extreme bytes, reused once, then only the second
    // byte changed so that its top two bits land in the milliseconds.
    send_word(8'hff, tewd_pkg::CODE_UTC_ONE);
    send_word(8'hff, tewd_pkg::CODE_UTC_TWO);
    send_word(8'h00, tewd_pkg::CODE_UTC_THREE);
    send_word(8'hff, tewd_pkg::CODE_UTC_FOUR);
    send_word(8'h00, tewd_pkg::CODE_UTC_DONE);
    send_word(8'hff, tewd_pkg::CODE_UTC_DONE);
    send_word(8'h40, tewd_pkg::CODE_UTC_TWO);
    send_word(8'h80, tewd_pkg::CODE_UTC_DONE);
  endtask

  // Random traffic: mostly well-formed day and UTC sequences and timing
  // events, with raw codes, lone storing or completing words and noise.
  task automatic send_random_traffic(input int unsigned count);
    int unsigned first;
    int unsigned pick;
    first = words_sent;
    while (words_sent - first < count) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3: begin
          send_word(rand_byte(), CODE_W'($urandom_range(0, 199)));
        end
        4, 5: begin
          if ($urandom_range(0, 3) != 0) send_word(rand_byte(), tewd_pkg::CODE_DAY_HIGH);
          if ($urandom_range(0, 3) != 0) send_word(rand_byte(), tewd_pkg::CODE_DAY_MID);
          send_word(rand_byte(), tewd_pkg::CODE_DAY_DONE);
        end
        6, 7: begin
          for (int k = 0; k < 4; k++) begin
            if ($urandom_range(0, 3) != 0) begin
              send_word(rand_byte(), tewd_pkg::CODE_UTC_ONE + CODE_W'(k));
            end
          end
          send_word(rand_byte(), tewd_pkg::CODE_UTC_DONE);
        end
        8: begin
          send_word(rand_byte(), CODE_W'($urandom_range(200, 255)));
        end
        default: begin
          send_word(rand_byte(), rand_byte());
        end
      endcase
    end
  endtask

  // Main sequence: reset, directed words, random traffic with idling, one
  // long receiver hold-off that fills the block, a full drain, more random
  // traffic, and a last part with no idling on either side.
  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    event_word = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();
    wait_reports_done();

    send_random_traffic(350);

    // The receiver stalls for a long stretch while timing events keep coming
    // back to back, so the block fills and holds off its input.
    idle_on  = 1'b0;
    hold_req = 1'b1;
    for (int k = 0; k < HOLD_WORDS; k++) begin
      send_word(rand_byte(), CODE_W'($urandom_range(0, 199)));
    end
    wait_reports_done();
    idle_on = 1'b1;

    send_random_traffic(350);
    // The sender pauses here until every report has come out.
    wait_reports_done();

    idle_on = 1'b0;
    send_random_traffic(200);

    wait_reports_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tewd_pkg.sv
sv/tewd_decode.sv
sv/timing_event_word_decoder.sv
sim/timing_event_word_decoder_tb.sv
